@@ rtl/core/gfp_pkg.sv @@
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared types and constants of the pairwise gravity force pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gfp_pkg;

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 8'd1;

  localparam logic [31:0] FORCE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] FORCE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [31:0] second_x;
    logic [31:0] second_y;
    logic [31:0] first_mass;
    logic [31:0] second_mass;
  } in_t;

  typedef struct packed {
    logic        negx;
    logic        negy;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [63:0] gm;
    logic [31:0] m2;
  } f1_t;

  typedef struct packed {
    logic        negx;
    logic        negy;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] gl;
    logic [63:0] gh;
    logic [63:0] md2;
  } f2_t;

  typedef struct packed {
    logic        negx;
    logic        negy;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [64:0] s;
    logic        close;
    logic [95:0] base;
  } f3_t;

  typedef struct packed {
    logic        negx;
    logic        negy;
    logic [64:0] s;
    logic        close;
    logic [63:0] px0;
    logic [63:0] px1;
    logic [63:0] px2;
    logic [63:0] py0;
    logic [63:0] py1;
    logic [63:0] py2;
  } f4_t;

  typedef struct packed {
    logic         negx;
    logic         negy;
    logic         close;
    logic [64:0]  s;
    logic [127:0] nx;
    logic [127:0] ny;
    logic [64:0]  rem;
    logic [32:0]  root;
  } sq_t;

  typedef struct packed {
    logic         negx;
    logic         negy;
    logic         close;
    logic [127:0] nx;
    logic [127:0] ny;
    logic [64:0]  p0;
    logic [65:0]  p1;
  } d1_t;

  typedef struct packed {
    logic         negx;
    logic         negy;
    logic         close;
    logic [127:0] nx;
    logic [127:0] ny;
    logic [97:0]  den;
  } d2_t;

  typedef struct packed {
    logic         negx;
    logic         negy;
    logic         close;
    logic         bigx;
    logic         bigy;
    logic [97:0]  den;
    logic [127:0] remx;
    logic [127:0] remy;
    logic [31:0]  qx;
    logic [31:0]  qy;
  } dv_t;

  typedef struct packed {
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic        too_close;
    logic        saturated;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/core/gfp_ifs.sv @@
// ----------------------------------------------------------------------------
// gfp_ifs
// Valid/ready channels of the gravity force block: input, result, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic        [31:0] first_mass;
  logic        [31:0] second_mass;

  modport source (output valid, first_x, first_y, second_x, second_y,
                  first_mass, second_mass, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y,
                  first_mass, second_mass, output ready);
endinterface

interface gfp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic               too_close;
  logic               saturated;

  modport source (output valid, force_x, force_y, too_close, saturated, input ready);
  modport sink   (input valid, force_x, force_y, too_close, saturated, output ready);
endinterface

interface gfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gfp_front.sv @@
// ----------------------------------------------------------------------------
// gfp_front
// Five stages: deltas, squares and mass products, distance sum and
// numerators, ending in the seed of the square root.
// ----------------------------------------------------------------------------
`default_nettype none

module gfp_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [31:0]  gravity,
  input  wire logic [31:0]  min_dist,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire gfp_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output gfp_pkg::sq_t      out_data
);
  import gfp_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  f1_t  d1_r, d1_nxt;
  f2_t  d2_r, d2_nxt;
  f3_t  d3_r, d3_nxt;
  f4_t  d4_r, d4_nxt;
  sq_t  d5_r, d5_nxt;
  logic [32:0] dx, dy, ndx, ndy;

  assign rdy5 = !v5_r || out_ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v5_r;
  assign out_data  = d5_r;

  always_comb begin
    dx  = {in_data.second_x[31], in_data.second_x} - {in_data.first_x[31], in_data.first_x};
    dy  = {in_data.second_y[31], in_data.second_y} - {in_data.first_y[31], in_data.first_y};
    ndx = -dx;
    ndy = -dy;
    d1_nxt.negx = dx[32];
    d1_nxt.negy = dy[32];
    d1_nxt.ax   = dx[32] ? ndx[31:0] : dx[31:0];
    d1_nxt.ay   = dy[32] ? ndy[31:0] : dy[31:0];
    d1_nxt.gm   = {32'b0, gravity} * {32'b0, in_data.first_mass};
    d1_nxt.m2   = in_data.second_mass;
  end

  always_comb begin
    d2_nxt.negx = d1_r.negx;
    d2_nxt.negy = d1_r.negy;
    d2_nxt.ax   = d1_r.ax;
    d2_nxt.ay   = d1_r.ay;
    d2_nxt.a    = {32'b0, d1_r.ax} * {32'b0, d1_r.ax};
    d2_nxt.b    = {32'b0, d1_r.ay} * {32'b0, d1_r.ay};
    d2_nxt.gl   = {32'b0, d1_r.gm[31:0]} * {32'b0, d1_r.m2};
    d2_nxt.gh   = {32'b0, d1_r.gm[63:32]} * {32'b0, d1_r.m2};
    d2_nxt.md2  = {32'b0, min_dist} * {32'b0, min_dist};
  end

  always_comb begin
    d3_nxt.negx  = d2_r.negx;
    d3_nxt.negy  = d2_r.negy;
    d3_nxt.ax    = d2_r.ax;
    d3_nxt.ay    = d2_r.ay;
    d3_nxt.s     = {1'b0, d2_r.a} + {1'b0, d2_r.b};
    d3_nxt.close = d3_nxt.s <= {1'b0, d2_r.md2};
    d3_nxt.base  = {32'b0, d2_r.gl} + {d2_r.gh, 32'b0};
  end

  always_comb begin
    d4_nxt.negx  = d3_r.negx;
    d4_nxt.negy  = d3_r.negy;
    d4_nxt.s     = d3_r.s;
    d4_nxt.close = d3_r.close;
    d4_nxt.px0   = {32'b0, d3_r.base[31:0]}  * {32'b0, d3_r.ax};
    d4_nxt.px1   = {32'b0, d3_r.base[63:32]} * {32'b0, d3_r.ax};
    d4_nxt.px2   = {32'b0, d3_r.base[95:64]} * {32'b0, d3_r.ax};
    d4_nxt.py0   = {32'b0, d3_r.base[31:0]}  * {32'b0, d3_r.ay};
    d4_nxt.py1   = {32'b0, d3_r.base[63:32]} * {32'b0, d3_r.ay};
    d4_nxt.py2   = {32'b0, d3_r.base[95:64]} * {32'b0, d3_r.ay};
  end

  always_comb begin
    d5_nxt.negx  = d4_r.negx;
    d5_nxt.negy  = d4_r.negy;
    d5_nxt.close = d4_r.close;
    d5_nxt.s     = d4_r.s;
    d5_nxt.nx    = {64'b0, d4_r.px0} + {32'b0, d4_r.px1, 32'b0} + {d4_r.px2, 64'b0};
    d5_nxt.ny    = {64'b0, d4_r.py0} + {32'b0, d4_r.py1, 32'b0} + {d4_r.py2, 64'b0};
    d5_nxt.rem   = d4_r.s;
    d5_nxt.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) d1_r <= d1_nxt;
    if (rdy2 && v1_r)     d2_r <= d2_nxt;
    if (rdy3 && v2_r)     d3_r <= d3_nxt;
    if (rdy4 && v3_r)     d4_r <= d4_nxt;
    if (rdy5 && v4_r)     d5_r <= d5_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/gfp_sqrt_step.sv @@
// ----------------------------------------------------------------------------
// gfp_sqrt_step
// One registered step of the integer square root: decides root bit BIT.
// ----------------------------------------------------------------------------
`default_nettype none

module gfp_sqrt_step #(
  parameter int BIT = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire gfp_pkg::sq_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output gfp_pkg::sq_t      out_data
);
  import gfp_pkg::*;

  logic        v_r;
  sq_t         d_r, d_nxt;
  logic [66:0] trial;
  logic [66:0] rem_w;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  // trial = 2*root*2^BIT + 2^(2*BIT), the growth of root^2 when bit BIT is set
  always_comb begin
    trial = ({34'b0, in_data.root} << (BIT + 1)) + (67'd1 << (2 * BIT));
    rem_w = {2'b0, in_data.rem};
    d_nxt = in_data;
    if (rem_w >= trial) begin
      rem_w          = rem_w - trial;
      d_nxt.rem      = rem_w[64:0];
      d_nxt.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) d_r <= d_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/gfp_div_step.sv @@
// ----------------------------------------------------------------------------
// gfp_div_step
// One registered restoring-division step: quotient bit BIT of both
// force components against the shared denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module gfp_div_step #(
  parameter int BIT = 31
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire gfp_pkg::dv_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output gfp_pkg::dv_t      out_data
);
  import gfp_pkg::*;

  logic         v_r;
  dv_t          d_r, d_nxt;
  logic [129:0] dsh;
  logic [129:0] dfx, dfy;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = d_r;

  always_comb begin
    dsh   = {32'b0, in_data.den} << BIT;
    dfx   = {2'b0, in_data.remx} - dsh;
    dfy   = {2'b0, in_data.remy} - dsh;
    d_nxt = in_data;
    if ({2'b0, in_data.remx} >= dsh) begin
      d_nxt.remx    = dfx[127:0];
      d_nxt.qx[BIT] = 1'b1;
    end
    if ({2'b0, in_data.remy} >= dsh) begin
      d_nxt.remy    = dfy[127:0];
      d_nxt.qy[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) d_r <= d_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/pairwise_gravity_force.sv @@
// Throughput: one body pair per cycle while the result side accepts every
//   transfer; the 33-step square-root line and the 32-step divider line
//   are fully pipelined, one bit per stage.
// Reset: synchronous, active low; empties every stage and loads
//   G = 1.0 and the minimum distance 0.01 in the current fixed-point format.
// ----------------------------------------------------------------------------
// pairwise_gravity_force
// Newtonian gravity force on the first of two bodies in fixed point:
// G*m1*m2*(p2-p1)/d^3, zero at or within a minimum distance, saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_gravity_force #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gfp_in_if.sink     in_chan,
  gfp_out_if.source  out_chan,
  gfp_cfg_if.sink    cfg_chan
);
  import gfp_pkg::*;

  localparam int SQ_STEPS  = 33;
  localparam int DIV_STEPS = 32;
  localparam logic [31:0] GRAVITY_RST = 32'(64'd1 << FRACTION_BITS);
  localparam logic [31:0] MIN_RST     = 32'((64'd1 << FRACTION_BITS) / 100);

  // Configuration: accept every write; unknown indexes are dropped.
  logic [31:0] gravity_r, min_dist_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r  <= GRAVITY_RST;
      min_dist_r <= MIN_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_GRAVITY:  gravity_r  <= cfg_chan.data;
        REG_MIN_DIST: min_dist_r <= cfg_chan.data;
        default:      ;
      endcase
    end
  end

  // Front end: deltas, squares, mass products and the two numerators.
  in_t in_pl;

  assign in_pl.first_x     = in_chan.first_x;
  assign in_pl.first_y     = in_chan.first_y;
  assign in_pl.second_x    = in_chan.second_x;
  assign in_pl.second_y    = in_chan.second_y;
  assign in_pl.first_mass  = in_chan.first_mass;
  assign in_pl.second_mass = in_chan.second_mass;

  logic sq_v   [SQ_STEPS+1];
  logic sq_rdy [SQ_STEPS+1];
  sq_t  sq_d   [SQ_STEPS+1];

  gfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .gravity   (gravity_r),
    .min_dist  (min_dist_r),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_data   (in_pl),
    .out_valid (sq_v[0]),
    .out_ready (sq_rdy[0]),
    .out_data  (sq_d[0])
  );

  // Square-root line: one root bit per stage, most significant first.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    gfp_sqrt_step #(.BIT(SQ_STEPS - 1 - k)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_data   (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  // Denominator S*d: two partial products, then their sum, then the
  // overflow test that decides whether the quotient reaches 2^32.
  logic dv_v   [DIV_STEPS+1];
  logic dv_rdy [DIV_STEPS+1];
  dv_t  dv_d   [DIV_STEPS+1];

  logic e1_v_r, e2_v_r, e3_v_r;
  logic e1_rdy, e2_rdy, e3_rdy;
  d1_t  e1_r, e1_nxt;
  d2_t  e2_r, e2_nxt;
  dv_t  e3_r, e3_nxt;

  assign e3_rdy = !e3_v_r || dv_rdy[0];
  assign e2_rdy = !e2_v_r || e3_rdy;
  assign e1_rdy = !e1_v_r || e2_rdy;
  assign sq_rdy[SQ_STEPS] = e1_rdy;
  assign dv_v[0] = e3_v_r;
  assign dv_d[0] = e3_r;

  always_comb begin
    e1_nxt.negx  = sq_d[SQ_STEPS].negx;
    e1_nxt.negy  = sq_d[SQ_STEPS].negy;
    e1_nxt.close = sq_d[SQ_STEPS].close;
    e1_nxt.nx    = sq_d[SQ_STEPS].nx;
    e1_nxt.ny    = sq_d[SQ_STEPS].ny;
    e1_nxt.p0    = {33'b0, sq_d[SQ_STEPS].s[31:0]} * {32'b0, sq_d[SQ_STEPS].root};
    e1_nxt.p1    = {33'b0, sq_d[SQ_STEPS].s[64:32]} * {33'b0, sq_d[SQ_STEPS].root};
  end

  always_comb begin
    e2_nxt.negx  = e1_r.negx;
    e2_nxt.negy  = e1_r.negy;
    e2_nxt.close = e1_r.close;
    e2_nxt.nx    = e1_r.nx;
    e2_nxt.ny    = e1_r.ny;
    e2_nxt.den   = {33'b0, e1_r.p0} + {e1_r.p1, 32'b0};
  end

  always_comb begin
    e3_nxt.negx  = e2_r.negx;
    e3_nxt.negy  = e2_r.negy;
    e3_nxt.close = e2_r.close;
    e3_nxt.bigx  = {2'b0, e2_r.nx} >= {e2_r.den, 32'b0};
    e3_nxt.bigy  = {2'b0, e2_r.ny} >= {e2_r.den, 32'b0};
    e3_nxt.den   = e2_r.den;
    e3_nxt.remx  = e2_r.nx;
    e3_nxt.remy  = e2_r.ny;
    e3_nxt.qx    = '0;
    e3_nxt.qy    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
    end else begin
      if (e1_rdy) e1_v_r <= sq_v[SQ_STEPS];
      if (e2_rdy) e2_v_r <= e1_v_r;
      if (e3_rdy) e3_v_r <= e2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e1_rdy && sq_v[SQ_STEPS]) e1_r <= e1_nxt;
    if (e2_rdy && e1_v_r)         e2_r <= e2_nxt;
    if (e3_rdy && e2_v_r)         e3_r <= e3_nxt;
  end

  // Divider line: one quotient bit of each component per stage.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    gfp_div_step #(.BIT(DIV_STEPS - 1 - k)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_v[k]),
      .in_ready  (dv_rdy[k]),
      .in_data   (dv_d[k]),
      .out_valid (dv_v[k+1]),
      .out_ready (dv_rdy[k+1]),
      .out_data  (dv_d[k+1])
    );
  end

  // Output register: apply sign, clip to range, force zero when too close.
  // Hold the result until the sink takes the transfer.
  logic out_v_r, out_rdy;
  out_t res_r, res_nxt;
  dv_t  fin;
  logic satx, saty;

  assign fin     = dv_d[DIV_STEPS];
  assign out_rdy = !out_v_r || out_chan.ready;
  assign dv_rdy[DIV_STEPS] = out_rdy;

  always_comb begin
    satx = fin.negx ? (fin.bigx || fin.qx > FORCE_MIN) : (fin.bigx || fin.qx[31]);
    saty = fin.negy ? (fin.bigy || fin.qy > FORCE_MIN) : (fin.bigy || fin.qy[31]);
    if (fin.close) begin
      res_nxt.force_x   = '0;
      res_nxt.force_y   = '0;
      res_nxt.too_close = 1'b1;
      res_nxt.saturated = 1'b0;
    end else begin
      if (satx)           res_nxt.force_x = fin.negx ? FORCE_MIN : FORCE_MAX;
      else if (fin.negx)  res_nxt.force_x = -fin.qx;
      else                res_nxt.force_x = fin.qx;
      if (saty)           res_nxt.force_y = fin.negy ? FORCE_MIN : FORCE_MAX;
      else if (fin.negy)  res_nxt.force_y = -fin.qy;
      else                res_nxt.force_y = fin.qy;
      res_nxt.too_close = 1'b0;
      res_nxt.saturated = satx || saty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && dv_v[DIV_STEPS]) res_r <= res_nxt;
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.force_x   = res_r.force_x;
  assign out_chan.force_y   = res_r.force_y;
  assign out_chan.too_close = res_r.too_close;
  assign out_chan.saturated = res_r.saturated;

endmodule

`default_nettype wire

@@ tb/tb_pairwise_gravity_force.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pairwise_gravity_force
// Streams body pairs through the gravity force block under random idling on
// both channels, predicts each force in wide integer arithmetic and checks
// every result transfer against the oldest prediction. Covers both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pairwise_gravity_force;
  import gfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  logic clk;
  logic rst_n;

  gfp_in_if  in_chan ();
  gfp_out_if out_chan ();
  gfp_cfg_if cfg_chan ();

  pairwise_gravity_force DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source),
    .cfg_chan(cfg_chan.sink)
  );

  // Shadow copies of the two registers, as the block should hold them.
  logic [31:0] grav_const;
  logic [31:0] min_dist;

  out_t force_queue[$];
  int   fail_count;
  int   idle_cycles;
  bit   calm;   // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the force on the first body for one pair.
  function automatic out_t predict_force(in_t p);
    out_t        r;
    logic signed [33:0] dx, dy;
    logic [32:0]  ax, ay;
    logic [65:0]  s;
    logic [65:0]  md2;
    logic [33:0]  span;
    logic [99:0]  den;
    logic [191:0] base, nx, ny, qx, qy;
    dx = $signed({{2{p.second_x[31]}}, p.second_x}) - $signed({{2{p.first_x[31]}}, p.first_x});
    dy = $signed({{2{p.second_y[31]}}, p.second_y}) - $signed({{2{p.first_y[31]}}, p.first_y});
    ax = dx < 0 ? 33'(-dx) : 33'(dx);
    ay = dy < 0 ? 33'(-dy) : 33'(dy);
    s = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    md2 = 66'(min_dist) * 66'(min_dist);
    r = '0;
    if (s <= md2) begin
      r.too_close = 1'b1;
      return r;
    end
    // Integer square root, bit by bit.
    span = '0;
    for (int b = 33; b >= 0; b--) begin
      logic [33:0] t;
      t = span | (34'd1 << b);
      if (68'(t) * 68'(t) <= 68'(s)) span = t;
    end
    den  = 100'(s) * 100'(span);
    base = 192'(grav_const) * 192'(p.first_mass) * 192'(p.second_mass);
    nx = base * 192'(ax);
    ny = base * 192'(ay);
    qx = nx / 192'(den);
    qy = ny / 192'(den);
    if (dx < 0) begin
      if (qx > 192'h8000_0000) begin r.force_x = FORCE_MIN; r.saturated = 1'b1; end
      else r.force_x = 32'(-qx);
    end else begin
      if (qx > 192'h7FFF_FFFF) begin r.force_x = FORCE_MAX; r.saturated = 1'b1; end
      else r.force_x = 32'(qx);
    end
    if (dy < 0) begin
      if (qy > 192'h8000_0000) begin r.force_y = FORCE_MIN; r.saturated = 1'b1; end
      else r.force_y = 32'(-qy);
    end else begin
      if (qy > 192'h7FFF_FFFF) begin r.force_y = FORCE_MAX; r.saturated = 1'b1; end
      else r.force_y = 32'(qy);
    end
    return r;
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 14);
  endfunction

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_pairwise_gravity_force NOT OK");
        $finish;
      end
    end
  end

  // Result side: check each transfer, then choose the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (force_queue.size() == 0) begin
        $display("%0t: unexpected result fx=%h fy=%h", $time,
                 out_chan.force_x, out_chan.force_y);
        fail_count++;
      end else begin
        out_t e;
        e = force_queue.pop_front();
        if (out_chan.force_x !== e.force_x) begin
          $display("%0t: force_x expected %h actual %h", $time, e.force_x, out_chan.force_x);
          fail_count++;
        end
        if (out_chan.force_y !== e.force_y) begin
          $display("%0t: force_y expected %h actual %h", $time, e.force_y, out_chan.force_y);
          fail_count++;
        end
        if (out_chan.too_close !== e.too_close) begin
          $display("%0t: too_close expected %b actual %b", $time,
                   e.too_close, out_chan.too_close);
          fail_count++;
        end
        if (out_chan.saturated !== e.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time,
                   e.saturated, out_chan.saturated);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) out_chan.ready <= !take_break();

  // Hold one pair on the input channel until it transfers; valid stays up
  // for a back-to-back pair and drops only while idling or draining.
  task automatic send_pair(in_t p);
    while (take_break()) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.first_x     <= p.first_x;
    in_chan.first_y     <= p.first_y;
    in_chan.second_x    <= p.second_x;
    in_chan.second_y    <= p.second_y;
    in_chan.first_mass  <= p.first_mass;
    in_chan.second_mass <= p.second_mass;
    do @(posedge clk); while (!in_chan.ready);
    force_queue.push_back(predict_force(p));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    if (idx == REG_GRAVITY) grav_const = value;
    else if (idx == REG_MIN_DIST) min_dist = value;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Let the pipeline empty before touching the registers.
  task automatic drain();
    int n;
    n = 0;
    in_chan.valid <= 1'b0;
    while (force_queue.size() != 0) @(negedge clk);
    while (n < DRAIN_CYCLES) begin
      @(negedge clk);
      n++;
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(4))
      0: return $urandom_range(3) == 0 ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return $urandom();
      3: return 32'($urandom_range(65535));
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  function automatic in_t random_pair();
    in_t p;
    p.first_x     = rand_word();
    p.first_y     = rand_word();
    p.second_x    = $urandom_range(9) == 0 ? p.first_x : rand_word();
    p.second_y    = $urandom_range(9) == 0 ? p.first_y + $urandom_range(3) : rand_word();
    p.first_mass  = $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(1 << 20));
    p.second_mass = $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(1 << 20));
    return p;
  endfunction

  task automatic test_directed();
    in_t p;
    // Coincident bodies.
    p = '{32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000};
    send_pair(p);
    // Just inside and just outside the minimum distance.
    p = '{32'd0, 32'd0, 32'd655, 32'd0, 32'h0001_0000, 32'h0001_0000};
    send_pair(p);
    p = '{32'd0, 32'd0, 32'd656, 32'd0, 32'h0001_0000, 32'h0001_0000};
    send_pair(p);
    // Unit distance, positive along x and negative along y.
    p = '{32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'h0001_0000};
    send_pair(p);
    p = '{32'd0, 32'd0, 32'd0, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000};
    send_pair(p);
    // Extreme span with heavy masses and with zero mass.
    p = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_pair(p);
    p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF};
    send_pair(p);
    // Close but heavy: saturate both ways.
    p = '{32'd0, 32'd0, 32'd1000, 32'hFFFF_FC18, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_pair(p);
    p = '{32'd1000, 32'd1000, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_pair(p);
    p = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000, 32'h0001_0001, 32'h00FF_0000,
          32'h0100_0000};
    send_pair(p);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pair(random_pair());
  endtask

  task automatic test_settings();
    // Zero G and zero minimum distance.
    drain();
    write_reg(REG_GRAVITY, 32'd0);
    write_reg(REG_MIN_DIST, 32'd0);
    test_random(150);
    // Largest G, tiny minimum distance; an unknown index must change nothing.
    drain();
    write_reg(REG_GRAVITY, 32'hFFFF_FFFF);
    write_reg(REG_MIN_DIST, 32'd1);
    write_reg(8'd7, 32'h1234_5678);
    test_random(250);
    // Largest minimum distance: nearly everything too close.
    drain();
    write_reg(REG_MIN_DIST, 32'hFFFF_FFFF);
    test_random(100);
    // Random mid-range settings.
    drain();
    write_reg(REG_GRAVITY, $urandom());
    write_reg(REG_MIN_DIST, $urandom_range(1 << 20));
    test_random(250);
  endtask

  initial begin
    rst_n          = 1'b0;
    calm           = 1'b0;
    fail_count     = 0;
    idle_cycles    = 0;
    in_chan.valid  = 1'b0;
    in_chan.first_x = '0;
    in_chan.first_y = '0;
    in_chan.second_x = '0;
    in_chan.second_y = '0;
    in_chan.first_mass = '0;
    in_chan.second_mass = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data  = '0;
    grav_const     = 32'h0001_0000;
    min_dist       = 32'd655;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(300);
    calm = 1'b1;          // long stretch with no idling on either side
    test_random(300);
    calm = 1'b0;
    test_settings();

    drain();
    if (fail_count == 0) begin
      $display("tb_pairwise_gravity_force OK");
    end else begin
      $display("tb_pairwise_gravity_force NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ pairwise_gravity_force.f @@
rtl/core/gfp_pkg.sv
rtl/core/gfp_ifs.sv
rtl/core/gfp_front.sv
rtl/core/gfp_sqrt_step.sv
rtl/core/gfp_div_step.sv
rtl/core/pairwise_gravity_force.sv
tb/tb_pairwise_gravity_force.sv
